// ----- rtl/led_pkg.sv -----
// Shared constants, types and cell controls for the line editor.
package led_pkg;

  localparam int LINE_CAP   = 16;
  localparam int HIST_DEPTH = 8;
  localparam int MAX_RES    = 64;

  localparam int CW  = 7;
  localparam int LW  = $clog2(LINE_CAP + 1);
  localparam int IW  = $clog2(LINE_CAP);
  localparam int HW  = $clog2(HIST_DEPTH);
  localparam int HCW = $clog2(HIST_DEPTH + 1);
  localparam int AW  = $clog2(HIST_DEPTH * LINE_CAP);
  localparam int RW  = $clog2(MAX_RES + 1);
  localparam int CFG_IW = 3;

  typedef logic [CW-1:0] char_t;

  localparam char_t BS_BYTE    = 7'h08;
  localparam char_t SPACE_BYTE = 7'h20;
  localparam char_t NL_BYTE    = 7'h0A;

  localparam logic [CFG_IW-1:0] CFG_ECHO   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ERASE  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_DELETE = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_EOT    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_UP     = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_DOWN   = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_LEFT   = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_RIGHT  = 3'd7;

  typedef struct packed {
    logic ld;       // take the load value
    logic shl;      // take the right neighbor
    logic shr;      // take the left neighbor
    logic save;     // copy line char into draft
    logic restore;  // copy draft char into line
  } cell_op_t;

endpackage

// ----- rtl/led_cell.sv -----
// One position of the line buffer with its draft copy.
module led_cell (
  input  logic             clk,
  input  led_pkg::cell_op_t op,
  input  led_pkg::char_t   ld_val,
  input  led_pkg::char_t   left_val,
  input  led_pkg::char_t   right_val,
  output led_pkg::char_t   line_q
);

  led_pkg::char_t line_r;
  led_pkg::char_t draft_r;

  always_ff @(posedge clk) begin
    if (op.ld) begin
      line_r <= ld_val;
    end else if (op.shl) begin
      line_r <= right_val;
    end else if (op.shr) begin
      line_r <= left_val;
    end else if (op.restore) begin
      line_r <= draft_r;
    end
    if (op.save) begin
      draft_r <= line_r;
    end
  end

  assign line_q = line_r;

endmodule

// ----- rtl/led_hist.sv -----
// History ring storage: one write port, one registered read port.
module led_hist (
  input  logic                     clk,
  input  logic                     we,
  input  logic [led_pkg::AW-1:0]   waddr,
  input  led_pkg::char_t           wdata,
  input  logic [led_pkg::AW-1:0]   raddr,
  output led_pkg::char_t           rdata
);

  led_pkg::char_t mem [led_pkg::HIST_DEPTH * led_pkg::LINE_CAP];
  led_pkg::char_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/line_editor_with_history.sv -----
// Top level: key sequencer, line cell row, history ring and result output.
//
// One key code is taken on the in_ channel (in_valid, in_stall). The block
// raises in_stall while it works on a key and drops it when every result of
// that key has been handed to the output register. Results leave on the out_
// channel at most one per cycle, held while out_stall is high: out_channel 0 is
// an echo byte for the display, 1 a line byte for the reader, and out_last
// marks the final result of a key. A key passes through accept, echo, edit,
// delivery check and final flush, and each emit loop spends one more pass on
// its exit; a history browse reads each character from the history memory
// port, and a saved line writes each character to that port, all of it
// stretched by any receiver stall.
// The line buffer is a row of cells that all shift left or right together
// on erase, delete and insert, and copy to or from the draft as a whole row.
// When the receiver stalls, the sequencer holds in place outside idle; a
// finished result waits in the output register. Reset empties the line, the
// draft and the history and restores the default key codes; configuration
// writes on the cfg_ port are taken at any edge with cfg_we high and rst_n
// high.
module line_editor_with_history (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [6:0]                    in_key_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_channel,
  output logic [6:0]                    out_data_byte,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [led_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [6:0]                    cfg_wdata
);

  localparam int LC = led_pkg::LINE_CAP;
  localparam int HD = led_pkg::HIST_DEPTH;
  localparam int LW = led_pkg::LW;
  localparam int HW = led_pkg::HW;
  localparam int HCW = led_pkg::HCW;
  localparam int AW = led_pkg::AW;
  localparam int RW = led_pkg::RW;
  localparam logic [LW-1:0] LEN_MAX = LW'(LC - 1);
  localparam logic [LW-1:0] LEN_CAP = LW'(LC);
  localparam logic [HW-1:0] SLOT_TOP = HW'(HD - 1);
  localparam logic [HCW-1:0] HCNT_FULL = HCW'(HD);
  localparam logic [RW-1:0] RES_LIMIT = RW'(led_pkg::MAX_RES);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_ECHO     = 14'b00000000000010,
    S_EDIT     = 14'b00000000000100,
    S_TAIL     = 14'b00000000001000,
    S_BACK     = 14'b00000000010000,
    S_INS_TAIL = 14'b00000000100000,
    S_SAVE     = 14'b00000001000000,
    S_RP_BS    = 14'b00000010000000,
    S_RP_SP    = 14'b00000100000000,
    S_RP_BS2   = 14'b00001000000000,
    S_RP_LOAD  = 14'b00010000000000,
    S_RP_ECHO  = 14'b00100000000000,
    S_DELIV    = 14'b01000000000000,
    S_FLUSH    = 14'b10000000000000
  } state_t;

  function automatic logic [AW-1:0] hist_addr(input logic [HW-1:0] slot,
                                              input logic [LW-1:0] pos);
    hist_addr = AW'(slot) * AW'(LC) + AW'(pos);
  endfunction

  function automatic logic [LW-1:0] clamp_len(input logic [LW-1:0] l);
    clamp_len = (l > LEN_MAX) ? LEN_MAX : l;
  endfunction

  // configuration
  logic           echo_en_r;
  led_pkg::char_t erase_r, delete_r, eot_r, up_r, down_r, left_r, right_r;

  // control state
  state_t           state_r, state_nxt;
  led_pkg::char_t   key_r, key_nxt;
  logic [LW-1:0]    cur_r, cur_nxt, len_r, len_nxt, dlen_r, dlen_nxt;
  logic             vv_r, vv_nxt;
  logic [HW-1:0]    vi_r, vi_nxt, head_r, head_nxt;
  logic [HCW-1:0]   hcnt_r, hcnt_nxt;
  logic [LW-1:0]    hlen_r [HD];
  logic [LW-1:0]    hlen_nxt [HD];
  logic [LW-1:0]    idx_r, idx_nxt, bcnt_r, bcnt_nxt, src_len_r, src_len_nxt;
  led_pkg::char_t   back_r, back_nxt;
  logic             src_hist_r, src_hist_nxt;
  logic [RW-1:0]    res_cnt_r, res_cnt_nxt;
  logic             pend_v_r, pend_v_nxt, pend_ch_r, pend_ch_nxt;
  led_pkg::char_t   pend_b_r, pend_b_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ch_r, out_last_r;
  led_pkg::char_t   out_b_r;

  // per-cycle controls
  logic             go, can_adv, push, out_load, out_last_n;
  logic             em_v, em_ch;
  led_pkg::char_t   em_b;
  logic             cmd_ld, cmd_shl, cmd_shr, cmd_save, cmd_restore;
  logic [LW-1:0]    cmd_pos;
  led_pkg::char_t   cmd_val;
  logic             h_we;
  logic [AW-1:0]    h_waddr, h_raddr;
  led_pkg::char_t   h_wdata, h_rdata;
  led_pkg::char_t   line_q [LC];
  led_pkg::char_t   line_at;
  logic             is_nl;
  logic [LW-1:0]    cur_eff;
  logic [HW-1:0]    oldest, nidx, latest, vi_inc;

  assign can_adv = !out_valid_r || !out_stall;
  assign go      = can_adv || (state_r == S_IDLE);
  assign line_at = line_q[idx_r[led_pkg::IW-1:0]];
  assign latest  = (head_r == '0) ? SLOT_TOP : head_r - 1'b1;
  assign oldest  = (hcnt_r < HCNT_FULL) ? '0 : head_r;
  assign nidx    = !vv_r ? latest : ((vi_r == '0) ? SLOT_TOP : vi_r - 1'b1);
  assign vi_inc  = (vi_r == SLOT_TOP) ? '0 : vi_r + 1'b1;
  assign is_nl   = (key_r == led_pkg::NL_BYTE);
  assign cur_eff = (is_nl && cur_r < len_r) ? len_r : cur_r;

  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    cur_nxt      = cur_r;
    len_nxt      = len_r;
    dlen_nxt     = dlen_r;
    vv_nxt       = vv_r;
    vi_nxt       = vi_r;
    head_nxt     = head_r;
    hcnt_nxt     = hcnt_r;
    hlen_nxt     = hlen_r;
    idx_nxt      = idx_r;
    bcnt_nxt     = bcnt_r;
    src_len_nxt  = src_len_r;
    back_nxt     = back_r;
    src_hist_nxt = src_hist_r;
    res_cnt_nxt  = res_cnt_r;
    pend_v_nxt   = pend_v_r;
    pend_ch_nxt  = pend_ch_r;
    pend_b_nxt   = pend_b_r;
    em_v         = 1'b0;
    em_ch        = 1'b0;
    em_b         = '0;
    cmd_ld       = 1'b0;
    cmd_shl      = 1'b0;
    cmd_shr      = 1'b0;
    cmd_save     = 1'b0;
    cmd_restore  = 1'b0;
    cmd_pos      = cur_r;
    cmd_val      = key_r;
    h_we         = 1'b0;
    h_waddr      = hist_addr(head_r, idx_r);
    h_wdata      = line_at;
    h_raddr      = hist_addr(vi_r, idx_r);
    out_load     = 1'b0;
    out_last_n   = 1'b0;

    if (go) begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            key_nxt     = in_key_code;
            res_cnt_nxt = '0;
            state_nxt   = S_ECHO;
          end
        end
        S_ECHO: begin
          em_v = echo_en_r && key_r != up_r && key_r != down_r &&
                 key_r != left_r && key_r != right_r;
          em_b = key_r;
          state_nxt = S_EDIT;
        end
        S_EDIT: begin
          state_nxt = S_DELIV;
          idx_nxt   = '0;
          if (key_r == erase_r) begin
            if (cur_r != '0) begin
              cmd_shl   = 1'b1;
              cmd_pos   = cur_r - 1'b1;
              cur_nxt   = cur_r - 1'b1;
              len_nxt   = len_r - 1'b1;
              em_v      = 1'b1;
              em_b      = led_pkg::BS_BYTE;
              idx_nxt   = cur_r - 1'b1;
              back_nxt  = led_pkg::BS_BYTE;
              state_nxt = S_TAIL;
            end
          end else if (key_r == delete_r) begin
            if (cur_r < len_r) begin
              cmd_shl   = 1'b1;
              len_nxt   = len_r - 1'b1;
              idx_nxt   = cur_r;
              back_nxt  = left_r;
              state_nxt = S_TAIL;
            end
          end else if (key_r == left_r) begin
            if (cur_r != '0) begin
              cur_nxt = cur_r - 1'b1;
              em_v    = 1'b1;
              em_b    = left_r;
            end
          end else if (key_r == right_r) begin
            if (cur_r < len_r) begin
              cur_nxt = cur_r + 1'b1;
              em_v    = 1'b1;
              em_b    = right_r;
            end
          end else if (key_r == up_r) begin
            if (hcnt_r != '0 && (!vv_r || vi_r != oldest)) begin
              if (!vv_r) begin
                cmd_save = 1'b1;
                dlen_nxt = len_r;
              end
              vi_nxt       = nidx;
              vv_nxt       = 1'b1;
              src_hist_nxt = 1'b1;
              src_len_nxt  = clamp_len(hlen_r[nidx]);
              state_nxt    = S_RP_BS;
            end
          end else if (key_r == down_r) begin
            if (vv_r) begin
              if (vi_r == latest) begin
                vv_nxt       = 1'b0;
                vi_nxt       = '0;
                src_hist_nxt = 1'b0;
                src_len_nxt  = clamp_len(dlen_r);
              end else begin
                vi_nxt       = vi_inc;
                src_hist_nxt = 1'b1;
                src_len_nxt  = clamp_len(hlen_r[vi_inc]);
              end
              state_nxt = S_RP_BS;
            end
          end else if (key_r == eot_r) begin
            state_nxt = S_DELIV;
          end else begin
            cur_nxt = cur_eff;
            if ((!is_nl && len_r >= LEN_MAX) || len_r >= LEN_CAP) begin
              state_nxt = S_DELIV;
            end else if (cur_eff < len_r) begin
              cmd_shr   = 1'b1;
              cur_nxt   = cur_r + 1'b1;
              len_nxt   = len_r + 1'b1;
              idx_nxt   = cur_r;
              back_nxt  = left_r;
              state_nxt = S_INS_TAIL;
            end else begin
              cmd_ld  = 1'b1;
              cmd_pos = cur_eff;
              cur_nxt = cur_eff + 1'b1;
              len_nxt = cur_eff + 1'b1;
              if (is_nl && cur_eff != '0) begin
                state_nxt = S_SAVE;
              end
            end
          end
        end
        S_TAIL: begin
          em_v = 1'b1;
          if (idx_r < len_r) begin
            em_b    = line_at;
            idx_nxt = idx_r + 1'b1;
          end else begin
            em_b      = led_pkg::SPACE_BYTE;
            bcnt_nxt  = len_r - cur_r + 1'b1;
            state_nxt = S_BACK;
          end
        end
        S_INS_TAIL: begin
          if (idx_r < len_r) begin
            em_v    = 1'b1;
            em_b    = line_at;
            idx_nxt = idx_r + 1'b1;
          end else if (len_r == cur_r) begin
            // no characters right of the cursor: nothing to walk back over
            idx_nxt   = '0;
            state_nxt = S_DELIV;
          end else begin
            bcnt_nxt  = len_r - cur_r;
            state_nxt = S_BACK;
          end
        end
        S_BACK: begin
          em_v     = 1'b1;
          em_b     = back_r;
          bcnt_nxt = bcnt_r - 1'b1;
          if (bcnt_r <= LW'(1)) begin
            idx_nxt   = '0;
            state_nxt = S_DELIV;
          end
        end
        S_SAVE: begin
          // copy the line without its newline into the head slot
          if (idx_r < len_r - 1'b1) begin
            h_we    = 1'b1;
            idx_nxt = idx_r + 1'b1;
          end else begin
            hlen_nxt[head_r] = len_r - 1'b1;
            head_nxt  = (head_r == SLOT_TOP) ? '0 : head_r + 1'b1;
            if (hcnt_r < HCNT_FULL) begin
              hcnt_nxt = hcnt_r + 1'b1;
            end
            idx_nxt   = '0;
            state_nxt = S_DELIV;
          end
        end
        S_RP_BS: begin
          if (cur_r != '0) begin
            em_v    = 1'b1;
            em_b    = led_pkg::BS_BYTE;
            cur_nxt = cur_r - 1'b1;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_RP_SP;
          end
        end
        S_RP_SP: begin
          if (idx_r < len_r) begin
            em_v    = 1'b1;
            em_b    = led_pkg::SPACE_BYTE;
            idx_nxt = idx_r + 1'b1;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_RP_BS2;
          end
        end
        S_RP_BS2: begin
          if (idx_r < len_r) begin
            em_v    = 1'b1;
            em_b    = led_pkg::BS_BYTE;
            idx_nxt = idx_r + 1'b1;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_RP_LOAD;
          end
        end
        S_RP_LOAD: begin
          if (!src_hist_r) begin
            cmd_restore = 1'b1;
            len_nxt     = src_len_r;
            cur_nxt     = src_len_r;
            idx_nxt     = '0;
            state_nxt   = S_RP_ECHO;
          end else begin
            // read data is registered, so it arrives in the cycle after its address
            if (idx_r != '0) begin
              cmd_ld  = 1'b1;
              cmd_pos = idx_r - 1'b1;
              cmd_val = h_rdata;
            end
            if (idx_r == src_len_r) begin
              len_nxt   = src_len_r;
              cur_nxt   = src_len_r;
              idx_nxt   = '0;
              state_nxt = S_RP_ECHO;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
        S_RP_ECHO: begin
          if (idx_r < len_r) begin
            em_v    = 1'b1;
            em_b    = line_at;
            idx_nxt = idx_r + 1'b1;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_DELIV;
          end
        end
        S_DELIV: begin
          if (is_nl || key_r == eot_r) begin
            if (idx_r < len_r) begin
              em_v    = 1'b1;
              em_ch   = 1'b1;
              em_b    = line_at;
              idx_nxt = idx_r + 1'b1;
            end else begin
              len_nxt   = '0;
              cur_nxt   = '0;
              vv_nxt    = 1'b0;
              vi_nxt    = '0;
              state_nxt = S_FLUSH;
            end
          end else begin
            state_nxt = S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (pend_v_r) begin
            out_load   = 1'b1;
            out_last_n = 1'b1;
            pend_v_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end

    // drop zero echo bytes and anything past the per-key result limit
    push = em_v && (em_ch || em_b != '0) && (res_cnt_r < RES_LIMIT);
    if (push) begin
      res_cnt_nxt = res_cnt_r + 1'b1;
      if (pend_v_r) begin
        out_load = 1'b1;
      end
      pend_v_nxt  = 1'b1;
      pend_ch_nxt = em_ch;
      pend_b_nxt  = em_b;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // row of line cells
  for (genvar i = 0; i < LC; i++) begin : g_cell
    led_pkg::cell_op_t op;
    led_pkg::char_t    lv, rv;
    assign op.ld      = (cmd_ld || cmd_shr) && (cmd_pos == LW'(i));
    assign op.shl     = cmd_shl && (LW'(i) >= cmd_pos);
    assign op.shr     = cmd_shr && (LW'(i) > cmd_pos);
    assign op.save    = cmd_save;
    assign op.restore = cmd_restore;
    if (i == 0) begin : g_first
      assign lv = '0;
    end else begin : g_mid_l
      assign lv = line_q[i-1];
    end
    if (i == LC - 1) begin : g_last
      assign rv = '0;
    end else begin : g_mid_r
      assign rv = line_q[i+1];
    end
    led_cell u_cell (
      .clk       (clk),
      .op        (op),
      .ld_val    (cmd_val),
      .left_val  (lv),
      .right_val (rv),
      .line_q    (line_q[i])
    );
  end

  led_hist u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      len_r       <= '0;
      dlen_r      <= '0;
      vv_r        <= 1'b0;
      vi_r        <= '0;
      head_r      <= '0;
      hcnt_r      <= '0;
      hlen_r      <= '{default: '0};
      idx_r       <= '0;
      bcnt_r      <= '0;
      src_len_r   <= '0;
      src_hist_r  <= 1'b0;
      res_cnt_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      echo_en_r   <= 1'b1;
      erase_r     <= 7'd8;
      delete_r    <= 7'd127;
      eot_r       <= 7'd4;
      up_r        <= 7'd17;
      down_r      <= 7'd18;
      left_r      <= 7'd19;
      right_r     <= 7'd20;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      dlen_r      <= dlen_nxt;
      vv_r        <= vv_nxt;
      vi_r        <= vi_nxt;
      head_r      <= head_nxt;
      hcnt_r      <= hcnt_nxt;
      hlen_r      <= hlen_nxt;
      idx_r       <= idx_nxt;
      bcnt_r      <= bcnt_nxt;
      src_len_r   <= src_len_nxt;
      src_hist_r  <= src_hist_nxt;
      res_cnt_r   <= res_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          led_pkg::CFG_ECHO:   echo_en_r <= cfg_wdata[0];
          led_pkg::CFG_ERASE:  erase_r   <= cfg_wdata;
          led_pkg::CFG_DELETE: delete_r  <= cfg_wdata;
          led_pkg::CFG_EOT:    eot_r     <= cfg_wdata;
          led_pkg::CFG_UP:     up_r      <= cfg_wdata;
          led_pkg::CFG_DOWN:   down_r    <= cfg_wdata;
          led_pkg::CFG_LEFT:   left_r    <= cfg_wdata;
          led_pkg::CFG_RIGHT:  right_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    back_r    <= back_nxt;
    pend_ch_r <= pend_ch_nxt;
    pend_b_r  <= pend_b_nxt;
    if (out_load) begin
      out_ch_r   <= pend_ch_r;
      out_b_r    <= pend_b_r;
      out_last_r <= out_last_n;
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_channel   = out_ch_r;
  assign out_data_byte = out_b_r;
  assign out_last      = out_last_r;

  ap_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r) else $error("cursor beyond line end");

  ap_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_CAP) else $error("line length over capacity");

  ap_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r) else $error("result left pending at idle");

  ap_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= RES_LIMIT) else $error("result count over limit");

  ap_hcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= HCNT_FULL) else $error("history count over depth");

endmodule
